>>> hw/rtl/kdpc_pkg.sv
package kdpc_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [CntW-1:0] BounceTicksRst  = 16'd10;
  localparam logic [CntW-1:0] LongTicksRst    = 16'd500;
  localparam logic [CntW-1:0] VLongTicksRst   = 16'd2000;
  localparam logic [CntW-1:0] LockoutTicksRst = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOUNCE_TICKS  = 2'd0,
    CFG_LONG_TICKS    = 2'd1,
    CFG_VLONG_TICKS   = 2'd2,
    CFG_LOCKOUT_TICKS = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_NOTHING        = 4'd0,
    ST_BOUNCE_RELEASE = 4'd1,
    ST_FIRST_PRESS    = 4'd2,
    ST_BOUNCE_PRESS   = 4'd3,
    ST_HOLD_SHORT     = 4'd4,
    ST_HOLD_LONG      = 4'd5,
    ST_HOLD_LONGER    = 4'd6,
    ST_RELEASE_SHORT  = 4'd7,
    ST_RELEASE_LONG   = 4'd8
  } key_state_e;

  typedef struct packed {
    logic first_click;
    logic hold_long;
    logic hold_longer;
    logic hold_very_long;
    logic release_short;
    logic release_long;
    logic release_very_long;
  } key_ev_t;

endpackage

>>> hw/rtl/key_debounce_press_classifier.sv
// Channel | Direction | Handshake              | Word
// in      | sink      | in_valid_i, in_stall_o  | key_level_i, now_time_i
// out     | source    | out_valid_o, out_stall_i| key_state_o, ev_*_o, press_stamp_o,
//         |           |                         | release_stamp_o
// cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
// One word is accepted per cycle while the input is not stalled.
// The word is classified in one pass between the input register and the result register.
// Reset clears the counters, the time stamps and the thresholds to their defaults.
// A stall on the output holds the result; the input register then fills and stalls the input.
module key_debounce_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kdpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kdpc_pkg::CntW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          key_level_i,
  input  logic [kdpc_pkg::TimeW-1:0]    now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    key_state_o,
  output logic                          ev_first_click_o,
  output logic                          ev_hold_long_o,
  output logic                          ev_hold_longer_o,
  output logic                          ev_hold_very_long_o,
  output logic                          ev_release_short_o,
  output logic                          ev_release_long_o,
  output logic                          ev_release_very_long_o,
  output logic [kdpc_pkg::TimeW-1:0]    press_stamp_o,
  output logic [kdpc_pkg::TimeW-1:0]    release_stamp_o
);

  logic [kdpc_pkg::CntW-1:0] bounce_ticks_q, long_ticks_q, vlong_ticks_q, lockout_ticks_q;

  logic                       in_vld_q;
  logic                       in_level_q;
  logic [kdpc_pkg::TimeW-1:0] in_time_q;

  logic                      hold_act_q, hold_act_d;
  logic [kdpc_pkg::CntW-1:0] hold_cnt_q, hold_cnt_d;
  logic                      lock_act_q, lock_act_d;
  logic [kdpc_pkg::CntW-1:0] lock_cnt_q, lock_cnt_d;
  logic [kdpc_pkg::TimeW-1:0] press_time_q, press_time_d;
  logic [kdpc_pkg::TimeW-1:0] release_time_q, release_time_d;

  logic                   out_vld_q;
  kdpc_pkg::key_state_e   out_st_q, st_d;
  kdpc_pkg::key_ev_t      out_ev_q, ev_d;

  logic                      advance;
  logic                      pressed;
  logic [kdpc_pkg::CntW-1:0] cnt_inc;

  assign advance    = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_ticks_q  <= kdpc_pkg::BounceTicksRst;
      long_ticks_q    <= kdpc_pkg::LongTicksRst;
      vlong_ticks_q   <= kdpc_pkg::VLongTicksRst;
      lockout_ticks_q <= kdpc_pkg::LockoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (kdpc_pkg::cfg_idx_e'(cfg_idx_i))
        kdpc_pkg::CFG_BOUNCE_TICKS:  bounce_ticks_q  <= cfg_data_i;
        kdpc_pkg::CFG_LONG_TICKS:    long_ticks_q    <= cfg_data_i;
        kdpc_pkg::CFG_VLONG_TICKS:   vlong_ticks_q   <= cfg_data_i;
        kdpc_pkg::CFG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_level_q <= key_level_i;
      in_time_q  <= now_time_i;
    end
  end

  assign pressed = !in_level_q;
  assign cnt_inc = (hold_cnt_q == kdpc_pkg::CntMax) ? hold_cnt_q : hold_cnt_q + 1'b1;

  always_comb begin
    hold_act_d     = hold_act_q;
    hold_cnt_d     = hold_cnt_q;
    lock_act_d     = lock_act_q;
    lock_cnt_d     = lock_cnt_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    st_d           = kdpc_pkg::ST_NOTHING;
    ev_d           = '0;
    priority if (lock_act_q) begin
      st_d = kdpc_pkg::ST_BOUNCE_RELEASE;
      if (lock_cnt_q == '0) begin
        lock_act_d = 1'b0;
      end else begin
        lock_cnt_d = lock_cnt_q - 1'b1;
      end
    end else if (!hold_act_q) begin
      if (pressed) begin
        hold_act_d       = 1'b1;
        hold_cnt_d       = '0;
        press_time_d     = in_time_q;
        st_d             = kdpc_pkg::ST_FIRST_PRESS;
        ev_d.first_click = 1'b1;
      end
    end else begin
      hold_cnt_d = cnt_inc;
      if (cnt_inc < bounce_ticks_q) begin
        st_d = kdpc_pkg::ST_BOUNCE_PRESS;
      end else if (pressed) begin
        if (cnt_inc > long_ticks_q) begin
          st_d             = kdpc_pkg::ST_HOLD_LONGER;
          ev_d.hold_longer = 1'b1;
        end else if (cnt_inc == long_ticks_q) begin
          st_d           = kdpc_pkg::ST_HOLD_LONG;
          ev_d.hold_long = 1'b1;
        end else begin
          st_d = kdpc_pkg::ST_HOLD_SHORT;
        end
        ev_d.hold_very_long = (cnt_inc >= long_ticks_q) && (cnt_inc > vlong_ticks_q);
      end else begin
        release_time_d = in_time_q;
        lock_act_d     = 1'b1;
        lock_cnt_d     = lockout_ticks_q;
        hold_act_d     = 1'b0;
        if (cnt_inc >= long_ticks_q) begin
          st_d              = kdpc_pkg::ST_RELEASE_LONG;
          ev_d.release_long = 1'b1;
        end else begin
          st_d               = kdpc_pkg::ST_RELEASE_SHORT;
          ev_d.release_short = 1'b1;
        end
        ev_d.release_very_long = cnt_inc > vlong_ticks_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_act_q     <= 1'b0;
      hold_cnt_q     <= '0;
      lock_act_q     <= 1'b0;
      lock_cnt_q     <= '0;
      press_time_q   <= '0;
      release_time_q <= '0;
      out_vld_q      <= 1'b0;
    end else begin
      if (advance) begin
        hold_act_q     <= hold_act_d;
        hold_cnt_q     <= hold_cnt_d;
        lock_act_q     <= lock_act_d;
        lock_cnt_q     <= lock_cnt_d;
        press_time_q   <= press_time_d;
        release_time_q <= release_time_d;
      end
      if (!(out_vld_q && out_stall_i)) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_st_q <= st_d;
      out_ev_q <= ev_d;
    end
  end

  // The stamps change only when a new result is loaded, so they always match the held word.
  assign out_valid_o            = out_vld_q;
  assign key_state_o            = out_st_q;
  assign ev_first_click_o       = out_ev_q.first_click;
  assign ev_hold_long_o         = out_ev_q.hold_long;
  assign ev_hold_longer_o       = out_ev_q.hold_longer;
  assign ev_hold_very_long_o    = out_ev_q.hold_very_long;
  assign ev_release_short_o     = out_ev_q.release_short;
  assign ev_release_long_o      = out_ev_q.release_long;
  assign ev_release_very_long_o = out_ev_q.release_very_long;
  assign press_stamp_o          = press_time_q;
  assign release_stamp_o        = release_time_q;

endmodule

>>> hw/rtl/kdpc_checker.sv
module kdpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [3:0]                    key_state_o,
  input logic                          ev_first_click_o,
  input logic                          ev_hold_long_o,
  input logic                          ev_hold_longer_o,
  input logic                          ev_hold_very_long_o,
  input logic                          ev_release_short_o,
  input logic                          ev_release_long_o,
  input logic                          ev_release_very_long_o,
  input logic [kdpc_pkg::TimeW-1:0]    press_stamp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_state_o)
      && $stable(press_stamp_o))
    else $error("stalled result word changed");

  a_first_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ev_first_click_o == (key_state_o == kdpc_pkg::ST_FIRST_PRESS))
    else $error("first click event does not match state");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({ev_first_click_o, ev_hold_long_o, ev_hold_longer_o,
                              ev_release_short_o, ev_release_long_o}))
    else $error("more than one primary event in a word");

  a_very_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ev_hold_very_long_o || ev_release_very_long_o) |->
      (ev_hold_long_o || ev_hold_longer_o || ev_release_long_o
       || key_state_o == kdpc_pkg::ST_RELEASE_SHORT))
    else $error("very long event without a hold or release");

endmodule

bind key_debounce_press_classifier kdpc_checker u_kdpc_checker (.*);

>>> tb/key_debounce_press_classifier_tb.sv
`timescale 1ns / 100ps

module key_debounce_press_classifier_tb;

  localparam int unsigned TimeW   = kdpc_pkg::TimeW;
  localparam int unsigned CntW    = kdpc_pkg::CntW;
  localparam int unsigned CfgIdxW = kdpc_pkg::CfgIdxW;

  localparam int QuietLimit  = 2000;
  localparam int RandomWords = 900;
  localparam int NumDirRows  = 26;
  localparam int HoldMax     = int'(kdpc_pkg::CntMax);

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    kdpc_pkg::key_state_e state;
    kdpc_pkg::key_ev_t    ev;
    logic [TimeW-1:0]     press_stamp;
    logic [TimeW-1:0]     release_stamp;
  } tick_result_t;

  typedef struct packed {
    row_kind_e            kind;
    logic                 key_level;
    logic [TimeW-1:0]     stamp;
    logic [16:0]          reps;
    kdpc_pkg::cfg_idx_e   cfg_idx;
    logic [CntW-1:0]      cfg_value;
    logic                 typed;
    tick_result_t         want;
  } dir_row_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i    = kdpc_pkg::CFG_BOUNCE_TICKS;
  logic [CntW-1:0]    cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               key_level_i  = 1'b1;
  logic [TimeW-1:0]   now_time_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [3:0]         key_state_o;
  logic               ev_first_click_o;
  logic               ev_hold_long_o;
  logic               ev_hold_longer_o;
  logic               ev_hold_very_long_o;
  logic               ev_release_short_o;
  logic               ev_release_long_o;
  logic               ev_release_very_long_o;
  logic [TimeW-1:0]   press_stamp_o;
  logic [TimeW-1:0]   release_stamp_o;

  key_debounce_press_classifier i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .key_level_i            (key_level_i),
    .now_time_i             (now_time_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .key_state_o            (key_state_o),
    .ev_first_click_o       (ev_first_click_o),
    .ev_hold_long_o         (ev_hold_long_o),
    .ev_hold_longer_o       (ev_hold_longer_o),
    .ev_hold_very_long_o    (ev_hold_very_long_o),
    .ev_release_short_o     (ev_release_short_o),
    .ev_release_long_o      (ev_release_long_o),
    .ev_release_very_long_o (ev_release_very_long_o),
    .press_stamp_o          (press_stamp_o),
    .release_stamp_o        (release_stamp_o)
  );

  logic [CntW-1:0]  threshold [4] = '{kdpc_pkg::BounceTicksRst, kdpc_pkg::LongTicksRst,
                                      kdpc_pkg::VLongTicksRst, kdpc_pkg::LockoutTicksRst};
  int               hold_ctr    = -1;
  int               lockout_ctr = -1;
  logic [TimeW-1:0] press_ts    = '0;
  logic [TimeW-1:0] release_ts  = '0;

  tick_result_t     pending_results [$];
  int               mismatches   = 0;
  int               words_sent   = 0;
  int               quiet_cycles = 0;
  dir_row_t         directed_rows [NumDirRows];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic tick_result_t classify_tick(logic level, logic [TimeW-1:0] stamp);
    tick_result_t r;
    logic [CntW-1:0] c;
    r = '0;
    if (lockout_ctr >= 0) begin
      lockout_ctr--;
      r.state = kdpc_pkg::ST_BOUNCE_RELEASE;
    end else if (hold_ctr < 0) begin
      if (!level) begin
        hold_ctr = 0;
        press_ts = stamp;
        r.state = kdpc_pkg::ST_FIRST_PRESS;
        r.ev.first_click = 1'b1;
      end
    end else begin
      if (hold_ctr < HoldMax) hold_ctr++;
      c = hold_ctr[CntW-1:0];
      if (c >= threshold[kdpc_pkg::CFG_BOUNCE_TICKS]) begin
        if (!level) begin
          if (c >= threshold[kdpc_pkg::CFG_LONG_TICKS]) begin
            if (c > threshold[kdpc_pkg::CFG_LONG_TICKS]) begin
              r.state = kdpc_pkg::ST_HOLD_LONGER;
              r.ev.hold_longer = 1'b1;
            end else begin
              r.state = kdpc_pkg::ST_HOLD_LONG;
              r.ev.hold_long = 1'b1;
            end
            r.ev.hold_very_long = c > threshold[kdpc_pkg::CFG_VLONG_TICKS];
          end else begin
            r.state = kdpc_pkg::ST_HOLD_SHORT;
          end
        end else begin
          release_ts = stamp;
          lockout_ctr = int'(threshold[kdpc_pkg::CFG_LOCKOUT_TICKS]);
          if (c >= threshold[kdpc_pkg::CFG_LONG_TICKS]) begin
            r.state = kdpc_pkg::ST_RELEASE_LONG;
            r.ev.release_long = 1'b1;
          end else begin
            r.state = kdpc_pkg::ST_RELEASE_SHORT;
            r.ev.release_short = 1'b1;
          end
          r.ev.release_very_long = c > threshold[kdpc_pkg::CFG_VLONG_TICKS];
          hold_ctr = -1;
        end
      end else begin
        r.state = kdpc_pkg::ST_BOUNCE_PRESS;
      end
    end
    r.press_stamp = press_ts;
    r.release_stamp = release_ts;
    return r;
  endfunction

  function automatic dir_row_t tick_row(logic level, logic [TimeW-1:0] stamp, int reps);
    dir_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.key_level = level;
    row.stamp = stamp;
    row.reps = 17'(reps);
    return row;
  endfunction

  function automatic dir_row_t seen_row(logic level, logic [TimeW-1:0] stamp,
                                        kdpc_pkg::key_state_e st, kdpc_pkg::key_ev_t ev,
                                        logic [TimeW-1:0] press, logic [TimeW-1:0] rel);
    dir_row_t row;
    row = tick_row(level, stamp, 1);
    row.typed = 1'b1;
    row.want.state = st;
    row.want.ev = ev;
    row.want.press_stamp = press;
    row.want.release_stamp = rel;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(kdpc_pkg::cfg_idx_e idx, logic [CntW-1:0] value);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_value = value;
    return row;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CntW-1:0] pick_threshold(int top, bit allow_max);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1 && allow_max) return kdpc_pkg::CntMax;
    return CntW'($urandom_range(1, top));
  endfunction

  task automatic report_mismatch(string what, logic [TimeW-1:0] got, logic [TimeW-1:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [TimeW-1:0] got, logic [TimeW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_word(logic level, logic [TimeW-1:0] stamp, logic typed,
                           tick_result_t want);
    int gap;
    tick_result_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_level_i <= level;
    now_time_i  <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    predicted = classify_tick(level, stamp);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(kdpc_pkg::cfg_idx_e idx, logic [CntW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    threshold[idx] = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : out_stall_gen
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24))
        @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    tick_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected, key_state", TimeW'(key_state_o), '0);
      end else begin
        want = pending_results.pop_front();
        check_field("key_state", TimeW'(key_state_o), TimeW'(want.state));
        check_field("ev_first_click", TimeW'(ev_first_click_o),
                    TimeW'(want.ev.first_click));
        check_field("ev_hold_long", TimeW'(ev_hold_long_o), TimeW'(want.ev.hold_long));
        check_field("ev_hold_longer", TimeW'(ev_hold_longer_o),
                    TimeW'(want.ev.hold_longer));
        check_field("ev_hold_very_long", TimeW'(ev_hold_very_long_o),
                    TimeW'(want.ev.hold_very_long));
        check_field("ev_release_short", TimeW'(ev_release_short_o),
                    TimeW'(want.ev.release_short));
        check_field("ev_release_long", TimeW'(ev_release_long_o),
                    TimeW'(want.ev.release_long));
        check_field("ev_release_very_long", TimeW'(ev_release_very_long_o),
                    TimeW'(want.ev.release_very_long));
        check_field("press_stamp", press_stamp_o, want.press_stamp);
        check_field("release_stamp", release_stamp_o, want.release_stamp);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int random_goal;
    int phase_goal;
    int hold_len;
    int release_len;
    int burst;
    logic [CntW-1:0] bounce;
    logic [CntW-1:0] lockout;

    // The first rows run with the reset thresholds and the last ones with every threshold
    // at or near its top.
    directed_rows = '{
      seen_row(1'b1, 32'd0, kdpc_pkg::ST_NOTHING, kdpc_pkg::key_ev_t'(7'b0000000),
               32'd0, 32'd0),
      seen_row(1'b0, 32'hFFFF_FFFF, kdpc_pkg::ST_FIRST_PRESS,
               kdpc_pkg::key_ev_t'(7'b1000000), 32'hFFFF_FFFF, 32'd0),
      seen_row(1'b1, 32'd1, kdpc_pkg::ST_BOUNCE_PRESS, kdpc_pkg::key_ev_t'(7'b0000000),
               32'hFFFF_FFFF, 32'd0),
      cfg_row(kdpc_pkg::CFG_BOUNCE_TICKS, 16'd0),
      cfg_row(kdpc_pkg::CFG_LONG_TICKS, 16'd3),
      cfg_row(kdpc_pkg::CFG_VLONG_TICKS, 16'd4),
      cfg_row(kdpc_pkg::CFG_LOCKOUT_TICKS, 16'd0),
      tick_row(1'b0, 32'd100, 4),
      tick_row(1'b1, 32'd200, 1),
      tick_row(1'b0, 32'd300, 1),
      tick_row(1'b0, 32'd400, 1),
      tick_row(1'b1, 32'd500, 1),
      tick_row(1'b1, 32'd600, 1),
      tick_row(1'b1, 32'd0, 1),
      cfg_row(kdpc_pkg::CFG_BOUNCE_TICKS, 16'hFFFF),
      cfg_row(kdpc_pkg::CFG_LONG_TICKS, 16'hFFFF),
      cfg_row(kdpc_pkg::CFG_VLONG_TICKS, 16'hFFFE),
      cfg_row(kdpc_pkg::CFG_LOCKOUT_TICKS, 16'hFFFF),
      tick_row(1'b0, 32'd1000, 1),
      tick_row(1'b0, 32'd2000, 20),
      tick_row(1'b1, 32'h8000_0000, 1),
      tick_row(1'b0, 32'd5, 8),
      tick_row(1'b0, 32'd7, 1),
      tick_row(1'b1, 32'h7FFF_FFF0, 2),
      tick_row(1'b0, 32'h5555_AAAA, 1),
      tick_row(1'b1, 32'hAAAA_5555, 1)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_threshold(directed_rows[i].cfg_idx, directed_rows[i].cfg_value);
      end else begin
        for (int k = 0; k < int'(directed_rows[i].reps); k++) begin
          send_word(directed_rows[i].key_level, directed_rows[i].stamp + TimeW'(k),
                    directed_rows[i].typed, directed_rows[i].want);
        end
      end
    end

    random_goal = words_sent + RandomWords;
    while (words_sent < random_goal) begin
      settle();
      write_threshold(kdpc_pkg::CFG_BOUNCE_TICKS, pick_threshold(12, 1'b0));
      write_threshold(kdpc_pkg::CFG_LONG_TICKS, pick_threshold(30, 1'b1));
      write_threshold(kdpc_pkg::CFG_VLONG_TICKS, pick_threshold(45, 1'b1));
      write_threshold(kdpc_pkg::CFG_LOCKOUT_TICKS, pick_threshold(12, 1'b0));
      bounce = threshold[kdpc_pkg::CFG_BOUNCE_TICKS];
      lockout = threshold[kdpc_pkg::CFG_LOCKOUT_TICKS];
      phase_goal = words_sent + $urandom_range(40, 120);
      while (words_sent < phase_goal) begin
        if ($urandom_range(0, 4) == 0) begin
          burst = $urandom_range(1, 10);
          repeat (burst) send_word(1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
        end else begin
          // A press with bounce noise while the pin is not sampled, then a release with
          // noise during the lockout.
          hold_len = $urandom_range(0, 60);
          for (int k = 0; k <= hold_len; k++) begin
            send_word(k > 0 && k < int'(bounce) && $urandom_range(0, 2) == 0, $urandom,
                      1'b0, '0);
          end
          release_len = $urandom_range(1, int'(lockout) + 4);
          for (int k = 0; k < release_len; k++) begin
            send_word(!(k > 0 && k <= int'(lockout) && $urandom_range(0, 2) == 0),
                      $urandom, 1'b0, '0);
          end
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
